// ----- src/sha_pkg.sv -----
// ----------------------------------------------------------------------------
// sha_pkg
// Shared types and constants for the SHA-256 stream hasher.
// ----------------------------------------------------------------------------
package sha_pkg;

    localparam int unsigned BlockBytes = 64;
    localparam int unsigned Rounds     = 64;
    localparam int unsigned HashWords  = 8;
    localparam logic [7:0]  PadByte    = 8'h80;
    localparam logic [5:0]  LenStart   = 6'd56;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_RUN,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic       start;
    } t_run_ctl;

    function automatic logic [31:0] round_k(input logic [5:0] t);
        logic [31:0] k;
        case (t)
            6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
            6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
            6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
            6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
            6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
            6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    function automatic logic [31:0] init_h(input logic [2:0] i);
        logic [31:0] h;
        case (i)
            3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
            3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
            3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
            3'd6: h = 32'h1f83d9ab; 3'd7: h = 32'h5be0cd19;
            default: h = 32'h0;
        endcase
        return h;
    endfunction

endpackage

// ----- src/sha_stream_if.sv -----
// ----------------------------------------------------------------------------
// sha_in_if / sha_out_if
// Valid/ready channels for message items and digest words.
// ----------------------------------------------------------------------------
interface sha_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last;
    modport source (output valid, data_byte, has_byte, last, input ready);
    modport sink   (input valid, data_byte, has_byte, last, output ready);
endinterface

interface sha_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
    modport source (output valid, digest_word, word_index, last_word, input ready);
    modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

// ----- src/sha_core.sv -----
// ----------------------------------------------------------------------------
// sha_core
// Compression engine: 64 rounds, one per cycle. Message words come from a
// word-wide block memory for rounds 0..15 and from a 16-entry schedule memory
// afterwards. Hash state is held in registers and updated at the block end.
// ----------------------------------------------------------------------------
module sha_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sha_pkg::t_run_ctl i_ctl,
    input  logic [31:0]       i_blk_word,     // block word for round index r_t
    output logic [3:0]        o_blk_addr,
    output logic              o_busy,
    output logic              o_done,
    input  logic              i_hash_init,
    input  logic [2:0]        i_hash_sel,
    output logic [31:0]       o_hash_word
);

    // schedule memory; the four taps are read directly from this 16-word
    // register window, so one memory write per round suffices
    logic [31:0] r_w [16];
    logic [31:0] r_h [8];
    logic [31:0] r_a, r_b, r_c, r_d, r_e, r_f, r_g, r_hh;
    logic [6:0]  r_t;
    logic        r_run;
    logic        r_load;
    logic        r_done;

    logic [5:0]  t_idx;
    logic [31:0] w15, w2, w16, w7, sg0, sg1, wt;
    logic [31:0] big0, big1, chs, maj, t1, t2;

    assign t_idx      = r_t[5:0];
    // fetch word 0 in the load cycle, then one word ahead of the round
    assign o_blk_addr = r_load ? 4'd0 : t_idx[3:0] + 4'd1;
    assign o_busy     = r_run | r_load;
    assign o_done     = r_done;
    assign o_hash_word = r_h[i_hash_sel];

    assign w15 = r_w[4'(t_idx - 6'd15)];
    assign w2  = r_w[4'(t_idx - 6'd2)];
    assign w16 = r_w[t_idx[3:0]];
    assign w7  = r_w[4'(t_idx - 6'd7)];
    assign sg0 = {w15[6:0], w15[31:7]} ^ {w15[17:0], w15[31:18]} ^ (w15 >> 3);
    assign sg1 = {w2[16:0], w2[31:17]} ^ {w2[18:0], w2[31:19]} ^ (w2 >> 10);
    assign wt  = (t_idx < 6'd16) ? i_blk_word : (w16 + sg0 + w7 + sg1);

    assign big1 = {r_e[5:0], r_e[31:6]} ^ {r_e[10:0], r_e[31:11]} ^ {r_e[24:0], r_e[31:25]};
    assign chs  = (r_e & r_f) ^ (~r_e & r_g);
    assign t1   = r_hh + big1 + chs + sha_pkg::round_k(t_idx) + wt;
    assign big0 = {r_a[1:0], r_a[31:2]} ^ {r_a[12:0], r_a[31:13]} ^ {r_a[21:0], r_a[31:22]};
    assign maj  = (r_a & r_b) ^ (r_a & r_c) ^ (r_b & r_c);
    assign t2   = big0 + maj;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_load <= 1'b0;
            r_done <= 1'b0;
            r_t    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_load <= 1'b1;    // load step for the first block word read
                r_t    <= '0;
            end else if (r_load) begin
                r_load <= 1'b0;
                r_run  <= 1'b1;
            end else if (r_run) begin
                r_t <= r_t + 7'd1;
                if (t_idx == 6'(sha_pkg::Rounds - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_hash_init) begin
            for (int j = 0; j < 8; j++) r_h[j] <= sha_pkg::init_h(3'(j));
        end else if (r_done) begin
            r_h[0] <= r_h[0] + r_a;  r_h[1] <= r_h[1] + r_b;
            r_h[2] <= r_h[2] + r_c;  r_h[3] <= r_h[3] + r_d;
            r_h[4] <= r_h[4] + r_e;  r_h[5] <= r_h[5] + r_f;
            r_h[6] <= r_h[6] + r_g;  r_h[7] <= r_h[7] + r_hh;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_load) begin
            r_a <= r_h[0]; r_b <= r_h[1]; r_c <= r_h[2]; r_d <= r_h[3];
            r_e <= r_h[4]; r_f <= r_h[5]; r_g <= r_h[6]; r_hh <= r_h[7];
        end else if (r_run) begin
            r_w[t_idx[3:0]] <= wt;
            r_hh <= r_g; r_g <= r_f; r_f <= r_e; r_e <= r_d + t1;
            r_d <= r_c; r_c <= r_b; r_b <= r_a; r_a <= t1 + t2;
        end
    end

    a_done_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_run) else $error("done while running");
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.start |-> !o_busy) else $error("start while busy");
    a_load_then_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_load |=> r_run) else $error("load not followed by run");

endmodule

// ----- src/sha256_stream_hasher.sv -----
// ----------------------------------------------------------------------------
// sha256_stream_hasher
// SHA-256 over a byte stream: at most one byte per item, digest as eight words.
// ----------------------------------------------------------------------------
// A byte item is taken while the block is filling. The item that completes a
// 64-byte block starts a compression and stalls the input through a
// block-memory read, 64 rounds of the single round unit and a hash update.
// A last item then pads at one byte per cycle up to byte 63 before each
// padded compression, runs one or two padded compressions, and offers the
// eight digest words one per cycle while the output is ready.
// The block memory is 16 words of 32 bits, written byte-lane per item and
// read one word per round.
module sha256_stream_hasher (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sha_in_if.sink    in_ch,
    sha_out_if.source out_ch
);

    sha_pkg::t_state r_st, n_st;
    logic [5:0]  r_fill;
    logic [60:0] r_len;
    logic        r_two;       // second padded block still to come
    logic        r_pend;      // a message end is being processed
    logic        r_padded;    // pad byte already written
    logic [2:0]  r_oidx;
    logic [31:0] r_bmem [16];
    logic [31:0] r_bq;

    sha_pkg::t_run_ctl ctl;
    logic [3:0]  blk_addr;
    logic        busy, done;
    logic [31:0] hword;
    logic        acc, wr_en, hinit;
    logic [5:0]  wr_ptr;
    logic [7:0]  wr_byte;
    logic [63:0] bits;
    logic [5:0]  pad_ptr;

    sha_core u_core (
        .i_clk, .i_rst_n, .i_ctl(ctl), .i_blk_word(r_bq), .o_blk_addr(blk_addr),
        .o_busy(busy), .o_done(done), .i_hash_init(hinit), .i_hash_sel(r_oidx),
        .o_hash_word(hword)
    );

    assign bits    = {r_len, 3'b000};
    assign acc     = in_ch.valid && in_ch.ready;
    assign pad_ptr = in_ch.has_byte ? r_fill + 6'd1 : r_fill;

    assign out_ch.valid       = (r_st == sha_pkg::ST_OUT);
    assign out_ch.digest_word = hword;
    assign out_ch.word_index  = r_oidx;
    assign out_ch.last_word   = (r_oidx == 3'd7);

    always_comb begin
        n_st        = r_st;
        in_ch.ready = 1'b0;
        ctl         = '0;
        wr_en       = 1'b0;
        wr_ptr      = r_fill;
        wr_byte     = in_ch.data_byte;
        hinit       = 1'b0;
        case (r_st)
            sha_pkg::ST_IDLE: begin
                in_ch.ready = 1'b1;
                if (acc) begin
                    wr_en = in_ch.has_byte;
                    if (in_ch.has_byte && r_fill == 6'd63) begin
                        ctl.start = 1'b1;
                        n_st = sha_pkg::ST_RUN;
                    end else if (in_ch.last) begin
                        n_st = sha_pkg::ST_PAD;
                    end
                end
            end
            sha_pkg::ST_PAD: begin
                wr_en = 1'b1;
                if (!r_padded)
                    wr_byte = sha_pkg::PadByte;
                else if (r_fill >= sha_pkg::LenStart && !r_two)
                    wr_byte = bits[{3'(6'd63 - r_fill), 3'b000} +: 8];
                else
                    wr_byte = '0;
                if (r_fill == 6'd63) begin
                    ctl.start = 1'b1;
                    n_st = sha_pkg::ST_RUN;
                end
            end
            sha_pkg::ST_RUN: begin
                if (done)
                    n_st = !r_pend ? sha_pkg::ST_IDLE
                                   : ((!r_padded || r_two) ? sha_pkg::ST_PAD
                                                           : sha_pkg::ST_OUT);
            end
            sha_pkg::ST_OUT: begin
                if (out_ch.ready && r_oidx == 3'd7) begin
                    hinit = 1'b1;
                    n_st  = sha_pkg::ST_IDLE;
                end
            end
            default: n_st = sha_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= sha_pkg::ST_IDLE;
            r_fill   <= '0;
            r_len    <= '0;
            r_two    <= 1'b0;
            r_pend   <= 1'b0;
            r_padded <= 1'b0;
            r_oidx   <= '0;
        end else begin
            r_st <= n_st;
            if (r_st == sha_pkg::ST_IDLE && acc) begin
                if (in_ch.has_byte) begin
                    r_fill <= r_fill + 6'd1;
                    r_len  <= r_len + 61'd1;
                end
                if (in_ch.last) begin
                    r_pend <= 1'b1;
                    // pad byte goes to the next free slot
                    r_two  <= (pad_ptr >= sha_pkg::LenStart);
                end
            end else if (r_st == sha_pkg::ST_PAD) begin
                r_fill   <= r_fill + 6'd1;
                r_padded <= 1'b1;
            end else if (r_st == sha_pkg::ST_RUN && done && r_pend) begin
                // the length goes in the block after this one
                r_two <= 1'b0;
            end else if (r_st == sha_pkg::ST_OUT && out_ch.ready) begin
                r_oidx <= r_oidx + 3'd1;
                if (r_oidx == 3'd7) begin
                    r_fill   <= '0;
                    r_len    <= '0;
                    r_pend   <= 1'b0;
                    r_padded <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en)
            r_bmem[wr_ptr[5:2]][{~wr_ptr[1:0], 3'b000} +: 8] <= wr_byte;
        r_bq <= r_bmem[blk_addr];
    end

    a_out_only_in_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ch.valid |-> r_pend) else $error("digest without message end");
    a_no_in_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !in_ch.ready) else $error("input taken while compressing");
    a_idx_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_ch.valid && out_ch.ready && r_oidx != 3'd7) |=> out_ch.valid)
        else $error("digest burst broken");

endmodule

// ----- tb/sv/sha_digest_checker.sv -----
// ----------------------------------------------------------------------------
// sha_digest_checker
// Watches the message and digest channels, computes SHA-256 of each message
// as it streams in, and compares every digest word with the oldest expected.
// ----------------------------------------------------------------------------
module sha_digest_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [7:0]  i_in_byte,
    input  logic        i_in_has_byte,
    input  logic        i_in_last,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [31:0] i_out_word,
    input  logic [2:0]  i_out_index,
    input  logic        i_out_last,
    output int          o_errors,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last_word;
    } t_digest_word;

    localparam logic [31:0] K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };
    localparam logic [31:0] H0 [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    logic [31:0]  hash [8];
    logic [7:0]   blk [64];
    logic [5:0]   fill;
    logic [60:0]  msg_len;
    t_digest_word digest_q [$];

    function automatic logic [31:0] rotr(logic [31:0] v, int s);
        return (v >> s) | (v << (32 - s));
    endfunction

    task automatic compress();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] t1, t2, e, a;
        for (int t = 0; t < 64; t++) begin
            if (t < 16) begin
                w[t] = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
            end else begin
                w[t] = w[t-16] + w[t-7]
                     + (rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3))
                     + (rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10));
            end
        end
        v = hash;
        for (int t = 0; t < 64; t++) begin
            e  = v[4];
            a  = v[0];
            t1 = v[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25))
               + ((e & v[5]) ^ (~e & v[6])) + K[t] + w[t];
            t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22))
               + ((a & v[1]) ^ (a & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int j = 0; j < 8; j++) hash[j] += v[j];
    endtask

    task automatic absorb_item(logic [7:0] b, logic has_b, logic fin);
        int k;
        logic [63:0] bits;
        if (has_b) begin
            blk[fill] = b;
            fill      = fill + 6'd1;
            msg_len   = msg_len + 61'd1;
            if (fill == 0) compress();
        end
        if (fin) begin
            k = fill;
            blk[k++] = 8'h80;
            if (k > 56) begin
                while (k < 64) blk[k++] = 8'h00;
                compress();
                k = 0;
            end
            while (k < 56) blk[k++] = 8'h00;
            bits = {msg_len, 3'b000};
            for (int i = 0; i < 8; i++) blk[63-i] = bits[8*i +: 8];
            compress();
            for (int i = 0; i < 8; i++) digest_q.push_back({hash[i], 3'(i), i == 7});
            hash    = H0;
            fill    = '0;
            msg_len = '0;
        end
    endtask

    assign o_pending = digest_q.size();

    always @(posedge i_clk) begin
        t_digest_word exp_w;
        int n_err;
        n_err = 0;
        if (!i_rst_n) begin
            hash     = H0;
            fill     = '0;
            msg_len  = '0;
            o_errors <= 0;
            digest_q.delete();
        end else begin
            if (i_in_valid && i_in_ready) absorb_item(i_in_byte, i_in_has_byte, i_in_last);
            if (i_out_valid && i_out_ready) begin
                if (digest_q.size() == 0) begin
                    $error("unexpected digest word %h", i_out_word);
                    n_err++;
                end else begin
                    exp_w = digest_q.pop_front();
                    if (exp_w.word !== i_out_word) begin
                        $error("digest_word expected %h actual %h", exp_w.word, i_out_word);
                        n_err++;
                    end
                    if (exp_w.index !== i_out_index) begin
                        $error("word_index expected %0d actual %0d", exp_w.index, i_out_index);
                        n_err++;
                    end
                    if (exp_w.last_word !== i_out_last) begin
                        $error("last_word expected %b actual %b", exp_w.last_word, i_out_last);
                        n_err++;
                    end
                end
            end
            o_errors <= o_errors + n_err;
        end
    end
endmodule

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Streams directed and random messages into the SHA-256 hasher with random
// gaps on both channels; the checker predicts and compares each digest word.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   errors, pending;
    int   cycles = 0;
    bit   out_hold = 1'b0;

    sha_in_if  in_ch ();
    sha_out_if out_ch ();

    sha256_stream_hasher dut (.i_clk(i_clk), .i_rst_n(i_rst_n), .in_ch(in_ch), .out_ch(out_ch));

    sha_digest_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_ch.valid), .i_in_ready(in_ch.ready), .i_in_byte(in_ch.data_byte),
        .i_in_has_byte(in_ch.has_byte), .i_in_last(in_ch.last),
        .i_out_valid(out_ch.valid), .i_out_ready(out_ch.ready),
        .i_out_word(out_ch.digest_word), .i_out_index(out_ch.word_index),
        .i_out_last(out_ch.last_word), .o_errors(errors), .o_pending(pending)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        in_ch.valid = 1'b0;
        in_ch.data_byte = '0;
        in_ch.has_byte = 1'b0;
        in_ch.last = 1'b0;
    end

    function automatic int gap_len();
        if ($urandom_range(0, 9) < 6) return 0;
        if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
        return $urandom_range(10, 80);
    endfunction

    // receiver stalls, with idle-free stretches
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 2000000) begin
            $display("FAILURE");
            $finish;
        end
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (out_hold) begin
            out_ch.ready <= 1'b1;
        end else begin
            out_ch.ready <= (gap_len() == 0);
        end
    end

    task automatic send_item(logic [7:0] b, logic has_b, logic fin, bit no_gap);
        int g;
        g = no_gap ? 0 : gap_len();
        if (g > 0) begin
            in_ch.valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.data_byte <= b;
        in_ch.has_byte  <= has_b;
        in_ch.last      <= fin;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    task automatic send_message(int len, bit no_gap);
        for (int i = 0; i < len; i++) begin
            if (i == len - 1 && $urandom_range(0, 1)) begin
                send_item(8'($urandom), 1'b1, 1'b1, no_gap);
                return;
            end
            if ($urandom_range(0, 15) == 0) send_item(8'($urandom), 1'b0, 1'b0, no_gap);
            send_item(8'($urandom), 1'b1, 1'b0, no_gap);
        end
        send_item(8'($urandom), 1'b0, 1'b1, no_gap);
    endtask

    initial begin
        int len;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // directed: empty message, extremes, neither flag, padding boundaries
        send_item(8'hff, 1'b0, 1'b1, 1'b0);
        send_item(8'h00, 1'b1, 1'b0, 1'b0);
        send_item(8'hff, 1'b1, 1'b1, 1'b0);
        send_item(8'hff, 1'b0, 1'b0, 1'b0);
        send_item(8'hff, 1'b1, 1'b1, 1'b0);
        send_message(56, 1'b1);
        send_message(64, 1'b0);
        // random messages, mostly short
        for (int m = 0; m < 6; m++) begin
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 8);
            out_hold = ($urandom_range(0, 3) == 0);
            send_message(len, out_hold);
        end
        out_hold = 1'b0;
        in_ch.valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
